// ----- sv/cwc_pkg.sv -----
// ---------------------------------------------------------------------------
// cwc_pkg
// Shared constants, types and helpers for the case-insensitive whole-word
// counter: pattern geometry, ascii codes and configuration register indexes.
// ---------------------------------------------------------------------------
package cwc_pkg;

  // pattern and history geometry
  localparam int MAX_PATTERN = 16;
  localparam int HIST_DEPTH  = MAX_PATTERN + 1;
  localparam int PAT_IDX_W   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int FILL_W      = $clog2(HIST_DEPTH + 1);
  localparam int LEN_W       = 5;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int PAT_BITS    = 2 * CFG_DATA_W;

  // counter widths: internal saturating counter and the result field
  localparam int COUNT_WIDTH = 16;
  localparam int WORD_W      = 16;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // ascii codes
  localparam logic [7:0] ASCII_SPACE   = 8'd32;
  localparam logic [7:0] ASCII_UPPER_A = 8'd65;
  localparam logic [7:0] ASCII_UPPER_Z = 8'd90;
  localparam logic [7:0] ASCII_LOWER_A = 8'd97;
  localparam logic [7:0] ASCII_LOWER_Z = 8'd122;
  localparam logic [7:0] CASE_OFFSET   = ASCII_LOWER_A - ASCII_UPPER_A;

  typedef logic [7:0] byte_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LOW  = 2'd0,
    CFG_PAT_HIGH = 2'd1,
    CFG_PAT_LEN  = 2'd2
  } cfg_idx_e;

  // map upper-case letters onto lower case
  function automatic byte_t fold(input byte_t b);
    if (b >= ASCII_UPPER_A && b <= ASCII_UPPER_Z) begin
      return b + CASE_OFFSET;
    end
    return b;
  endfunction

  function automatic logic is_letter(input byte_t b);
    return (b >= ASCII_UPPER_A && b <= ASCII_UPPER_Z) ||
           (b >= ASCII_LOWER_A && b <= ASCII_LOWER_Z);
  endfunction

endpackage

// ----- sv/cwc_text_if.sv -----
// ---------------------------------------------------------------------------
// cwc_text_if
// Input channel of the word counter: one text byte per request.
// ---------------------------------------------------------------------------
interface cwc_text_if;
  logic           valid;
  logic           ready;
  cwc_pkg::byte_t text_byte;
  logic           end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

// ----- sv/cwc_result_if.sv -----
// ---------------------------------------------------------------------------
// cwc_result_if
// Result channel of the word counter: running count per text byte.
// ---------------------------------------------------------------------------
interface cwc_result_if;
  logic                       valid;
  logic                       ready;
  logic [cwc_pkg::WORD_W-1:0] word_count;
  logic                       text_done;

  modport source (output valid, output word_count, output text_done, input ready);
  modport sink   (input valid, input word_count, input text_done, output ready);
endinterface

// ----- sv/case_insensitive_word_counter.sv -----
// ---------------------------------------------------------------------------
// case_insensitive_word_counter
// Counts whole-word, case-insensitive occurrences of a configured pattern
// of up to 16 characters in a byte stream, overlaps included.
// ---------------------------------------------------------------------------
//  channel   | dir | handshake     | payload
//  ----------+-----+---------------+---------------------------------------
//  text_i    | in  | valid/ready   | text_byte[7:0], end_of_text
//  result_o  | out | valid/ready   | word_count[15:0], text_done
//  cfg       | in  | cfg_we_i      | cfg_idx_i[1:0], cfg_data_i[63:0]
//
//  one request per cycle unless the output is stalled; its result shows in
//  the output register in the cycle after acceptance; the compare is combinational
//  reset clears history to spaces, count to zero, pattern length to one
//  a stalled result holds the output register; a new request is taken
//  whenever the output register is empty or being drained in that cycle
// ---------------------------------------------------------------------------
module case_insensitive_word_counter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  cwc_text_if.sink                            text_i,
  cwc_result_if.source                        result_o,
  input  logic                                cfg_we_i,
  input  logic [cwc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [cwc_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int MaxPat = cwc_pkg::MAX_PATTERN;
  localparam int Depth  = cwc_pkg::HIST_DEPTH;
  localparam int CntW   = cwc_pkg::COUNT_WIDTH;

  // configuration registers
  logic [cwc_pkg::CFG_DATA_W-1:0] pat_low_q, pat_high_q;
  logic [cwc_pkg::LEN_W-1:0]      pat_len_q;

  // text state: folded history (newest first), fill level, count
  cwc_pkg::byte_t             hist_q [Depth];
  cwc_pkg::byte_t             hist_d [Depth];
  logic [cwc_pkg::FILL_W-1:0] fill_q, fill_d;
  logic [CntW-1:0]            count_q, count_d;

  // output register
  logic                       out_valid_q;
  logic [cwc_pkg::WORD_W-1:0] out_count_q;
  logic                       out_done_q;

  logic                        in_acc;
  cwc_pkg::byte_t              win [Depth+1];
  cwc_pkg::byte_t              pat [MaxPat];
  logic [cwc_pkg::PAT_BITS-1:0] pat_all;
  logic                        eq [Depth][MaxPat];
  logic [MaxPat-1:0]           hit_prev, hit_end;
  logic                        len_ok;
  logic [cwc_pkg::PAT_IDX_W-1:0] len_sel;
  logic                        bump_prev, bump_end;
  logic [CntW:0]               count_sum;

  // handshake
  assign text_i.ready = !out_valid_q || result_o.ready;
  assign in_acc       = text_i.valid && text_i.ready;

  assign result_o.valid      = out_valid_q;
  assign result_o.word_count = out_count_q;
  assign result_o.text_done  = out_done_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= cwc_pkg::LEN_W'(1);
    end else if (cfg_we_i) begin
      unique case (cwc_pkg::cfg_idx_e'(cfg_idx_i))
        cwc_pkg::CFG_PAT_LOW:  pat_low_q  <= cfg_data_i;
        cwc_pkg::CFG_PAT_HIGH: pat_high_q <= cfg_data_i;
        cwc_pkg::CFG_PAT_LEN:  pat_len_q  <= cfg_data_i[cwc_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // folded window: current byte then history
  assign pat_all = {pat_high_q, pat_low_q};

  always_comb begin
    win[0] = cwc_pkg::fold(text_i.text_byte);
    for (int j = 0; j < Depth; j++) begin
      win[j+1] = hist_q[j];
    end
    for (int i = 0; i < MaxPat; i++) begin
      pat[i] = cwc_pkg::fold(pat_all[8*i +: 8]);
    end
  end

  // every window byte against every pattern character
  always_comb begin
    for (int j = 0; j < Depth; j++) begin
      for (int i = 0; i < MaxPat; i++) begin
        eq[j][i] = (win[j] == pat[i]);
      end
    end
  end

  // candidate matches for each length, ending at the previous byte and at this one
  always_comb begin
    logic ok_prev, ok_end;
    for (int l = 1; l <= MaxPat; l++) begin
      ok_prev = 1'b1;
      ok_end  = 1'b1;
      for (int i = 0; i < MaxPat; i++) begin
        if (i < l) begin
          ok_prev = ok_prev && eq[l-i][i];
          ok_end  = ok_end && eq[l-1-i][i];
        end
      end
      hit_prev[l-1] = ok_prev && (win[l+1] == cwc_pkg::ASCII_SPACE) &&
                      (fill_q >= cwc_pkg::FILL_W'(l));
      hit_end[l-1]  = ok_end && (win[l] == cwc_pkg::ASCII_SPACE) &&
                      (fill_q >= cwc_pkg::FILL_W'(l - 1));
    end
  end

  // effective length: zero never matches, overlong clamps to the maximum
  always_comb begin
    len_ok  = (pat_len_q != '0);
    len_sel = cwc_pkg::PAT_IDX_W'(MaxPat - 1);
    if (pat_len_q <= cwc_pkg::LEN_W'(MaxPat) && len_ok) begin
      len_sel = cwc_pkg::PAT_IDX_W'(pat_len_q - cwc_pkg::LEN_W'(1));
    end
  end

  assign bump_prev = len_ok && hit_prev[len_sel] && !cwc_pkg::is_letter(text_i.text_byte);
  assign bump_end  = len_ok && text_i.end_of_text && hit_end[len_sel];

  // saturating count update
  always_comb begin
    count_sum = {1'b0, count_q} + (CntW+1)'(bump_prev) + (CntW+1)'(bump_end);
    count_d   = (count_sum > {1'b0, cwc_pkg::COUNT_MAX}) ? cwc_pkg::COUNT_MAX
                                                         : count_sum[CntW-1:0];
  end

  // next text state: shift in, or clear at end of text
  always_comb begin
    if (text_i.end_of_text) begin
      for (int j = 0; j < Depth; j++) begin
        hist_d[j] = cwc_pkg::ASCII_SPACE;
      end
      fill_d = '0;
    end else begin
      hist_d[0] = win[0];
      for (int j = 1; j < Depth; j++) begin
        hist_d[j] = hist_q[j-1];
      end
      fill_d = (fill_q < cwc_pkg::FILL_W'(Depth)) ? fill_q + cwc_pkg::FILL_W'(1) : fill_q;
    end
  end

  // text state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < Depth; j++) begin
        hist_q[j] <= cwc_pkg::ASCII_SPACE;
      end
      fill_q  <= '0;
      count_q <= '0;
    end else if (in_acc) begin
      hist_q  <= hist_d;
      fill_q  <= fill_d;
      count_q <= text_i.end_of_text ? '0 : count_d;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_count_q <= cwc_pkg::WORD_W'(count_d);
      out_done_q  <= text_i.end_of_text;
    end
  end

endmodule

// ----- sv/cwc_checker.sv -----
// ---------------------------------------------------------------------------
// cwc_checker
// Port-level checks for the word counter, bound to the top level.
// ---------------------------------------------------------------------------
module cwc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [cwc_pkg::WORD_W-1:0] word_count_i,
  input logic                       text_done_i
);

  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // an accepted request shows its result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_i)
    else $error("no result after accepted request");

  // an empty output register never stalls the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output register");

  // within a text the count grows by at most two per byte
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !text_done_i) ##1 out_acc |->
      (word_count_i >= $past(word_count_i)) &&
      (word_count_i - $past(word_count_i) <= cwc_pkg::WORD_W'(2)))
    else $error("count step out of range");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(word_count_i) &&
      $stable(text_done_i))
    else $error("stalled result changed");

endmodule

bind case_insensitive_word_counter cwc_checker u_cwc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (text_i.valid),
  .in_ready_i   (text_i.ready),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .word_count_i (result_o.word_count),
  .text_done_i  (result_o.text_done)
);

// ----- bench/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench
// Checks the case-insensitive whole-word counter against a predictor of the
// word count. Covers the reset pattern, case folding, overlapping words,
// pattern length limits, text end handling, a long run of words, and random
// texts with idle and stall bursts on both channels.
// ---------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [cwc_pkg::WORD_W-1:0] word_count;
    logic                       text_done;
  } tally_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i;
  logic [cwc_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [cwc_pkg::CFG_DATA_W-1:0] cfg_data_i;

  cwc_text_if   text_if ();
  cwc_result_if result_if ();

  // pattern registers as the counter should hold them
  logic [cwc_pkg::CFG_DATA_W-1:0] pat_lo = '0;
  logic [cwc_pkg::CFG_DATA_W-1:0] pat_hi = '0;
  logic [cwc_pkg::LEN_W-1:0]      pat_len = cwc_pkg::LEN_W'(1);

  // text history, newest byte first
  cwc_pkg::byte_t               history [cwc_pkg::HIST_DEPTH];
  cwc_pkg::byte_t               window [cwc_pkg::HIST_DEPTH+1];
  int unsigned                  hist_fill;
  logic [cwc_pkg::COUNT_WIDTH-1:0] word_tally;

  tally_t         expected_tallies [$];
  cwc_pkg::byte_t text_q [$];
  int             mismatch_count = 0;
  bit             idle_on = 1'b0;
  int             stall_left = 0;

  case_insensitive_word_counter DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .text_i     (text_if),
    .result_o   (result_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------

  function automatic cwc_pkg::byte_t to_lower(input cwc_pkg::byte_t b);
    if (b >= cwc_pkg::ASCII_UPPER_A && b <= cwc_pkg::ASCII_UPPER_Z) begin
      return b + (cwc_pkg::ASCII_LOWER_A - cwc_pkg::ASCII_UPPER_A);
    end
    return b;
  endfunction

  function automatic bit is_alpha(input cwc_pkg::byte_t b);
    return (b >= cwc_pkg::ASCII_UPPER_A && b <= cwc_pkg::ASCII_UPPER_Z) ||
           (b >= cwc_pkg::ASCII_LOWER_A && b <= cwc_pkg::ASCII_LOWER_Z);
  endfunction

  function automatic cwc_pkg::byte_t pattern_at(input int unsigned k);
    if (k < 8) begin
      return pat_lo[8*k +: 8];
    end
    return pat_hi[8*(k-8) +: 8];
  endfunction

  function automatic void clear_history();
    for (int j = 0; j < cwc_pkg::HIST_DEPTH; j++) history[j] = cwc_pkg::ASCII_SPACE;
    hist_fill  = 0;
    word_tally = '0;
  endfunction

  // a word of len bytes ending at window[e]; the follower is window[e-1]
  // or the end of the text when e is zero
  function automatic bit word_ends_at(input int unsigned e, input int unsigned len);
    if (len == 0 || e + len - 1 > hist_fill) begin
      return 1'b0;
    end
    for (int unsigned i = 0; i < len; i++) begin
      if (to_lower(window[e+len-1-i]) != to_lower(pattern_at(i))) begin
        return 1'b0;
      end
    end
    if (window[e+len] != cwc_pkg::ASCII_SPACE) begin
      return 1'b0;
    end
    if (e > 0 && is_alpha(window[e-1])) begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // expected count after one accepted text byte
  task automatic predict_tally(input cwc_pkg::byte_t b, input bit eot);
    int unsigned len;
    int unsigned hits;
    tally_t      want;
    len = (pat_len > cwc_pkg::MAX_PATTERN) ? cwc_pkg::MAX_PATTERN : pat_len;
    window[0] = b;
    for (int j = 0; j < cwc_pkg::HIST_DEPTH; j++) window[j+1] = history[j];
    hits = word_ends_at(1, len);
    if (eot) begin
      hits += word_ends_at(0, len);
    end
    for (int unsigned k = 0; k < hits; k++) begin
      if (word_tally != cwc_pkg::COUNT_MAX) begin
        word_tally++;
      end
    end
    want.word_count = word_tally;
    want.text_done  = eot;
    expected_tallies.push_back(want);
    if (eot) begin
      clear_history();
    end else begin
      for (int j = cwc_pkg::HIST_DEPTH - 1; j > 0; j--) history[j] = history[j-1];
      history[0] = b;
      if (hist_fill < cwc_pkg::HIST_DEPTH) begin
        hist_fill++;
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------

  // result side stalls in random bursts
  initial begin
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left == 0 && idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 5);
      end
      if (stall_left > 0) begin
        result_if.ready <= 1'b0;
        stall_left--;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  // one text request, held until accepted
  task automatic send_byte(input cwc_pkg::byte_t b, input bit eot);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      text_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    text_if.valid       <= 1'b1;
    text_if.text_byte   <= b;
    text_if.end_of_text <= eot;
    do @(posedge clk_i); while (text_if.ready !== 1'b1);
    predict_tally(b, eot);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(cwc_pkg::byte_t'(s[i]), i == s.len() - 1);
    end
  endtask

  // send the built text; optionally hold off halfway until all results are in
  task automatic send_queue(input bit pause_mid);
    for (int i = 0; i < text_q.size(); i++) begin
      if (pause_mid && i == text_q.size() / 2) begin
        wait_drained();
      end
      send_byte(text_q[i], i == text_q.size() - 1);
    end
  endtask

  task automatic wait_drained();
    text_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_tallies.size() != 0);
  endtask

  task automatic write_reg(input cwc_pkg::cfg_idx_e idx,
                           input logic [cwc_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      cwc_pkg::CFG_PAT_LOW:  pat_lo = data;
      cwc_pkg::CFG_PAT_HIGH: pat_hi = data;
      cwc_pkg::CFG_PAT_LEN:  pat_len = data[cwc_pkg::LEN_W-1:0];
      default: ;
    endcase
  endtask

  // all three registers, written once the counter is idle
  task automatic set_pattern(input logic [2*cwc_pkg::CFG_DATA_W-1:0] chars,
                             input logic [cwc_pkg::CFG_DATA_W-1:0] len_data);
    wait_drained();
    write_reg(cwc_pkg::CFG_PAT_LOW, chars[cwc_pkg::CFG_DATA_W-1:0]);
    write_reg(cwc_pkg::CFG_PAT_HIGH, chars[2*cwc_pkg::CFG_DATA_W-1:cwc_pkg::CFG_DATA_W]);
    write_reg(cwc_pkg::CFG_PAT_LEN, len_data);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [2*cwc_pkg::CFG_DATA_W-1:0] pack_chars(input string s);
    logic [2*cwc_pkg::CFG_DATA_W-1:0] v;
    v = '0;
    for (int k = 0; k < s.len() && k < cwc_pkg::MAX_PATTERN; k++) v[8*k +: 8] = s[k];
    return v;
  endfunction

  function automatic cwc_pkg::byte_t random_case(input cwc_pkg::byte_t b);
    if (is_alpha(b) && $urandom_range(0, 1)) begin
      return b ^ 8'h20;
    end
    return b;
  endfunction

  // ---------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    tally_t want;
    if (rst_ni && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
      if (expected_tallies.size() == 0) begin
        $error("unexpected result: word_count %0d text_done %0b",
               result_if.word_count, result_if.text_done);
        mismatch_count++;
      end else begin
        want = expected_tallies.pop_front();
        if (result_if.word_count !== want.word_count) begin
          $error("word_count: expected %0d, actual %0d",
                 want.word_count, result_if.word_count);
          mismatch_count++;
        end
        if (result_if.text_done !== want.text_done) begin
          $error("text_done: expected %0b, actual %0b",
                 want.text_done, result_if.text_done);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // reset pattern is a single zero byte; zero is an ordinary non-letter
  task automatic test_reset_pattern();
    send_byte(8'h00, 1'b1);
    send_byte(cwc_pkg::ASCII_SPACE, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(cwc_pkg::ASCII_UPPER_A, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(cwc_pkg::ASCII_SPACE, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // letters fold, neighbors of the letter ranges and high bytes do not
  task automatic test_case_folding();
    set_pattern(pack_chars("WoRd"), 64'd4);
    send_text("word WORD, wOrDs\tword word1 [ord");
    set_pattern(pack_chars("@[`{"), 64'd4);
    send_text(" @[`{ `{@[ @[`{");
    set_pattern({120'd0, 8'hC1}, 64'd1);
    send_byte(cwc_pkg::ASCII_SPACE, 1'b0);
    send_byte(8'hE1, 1'b0);
    send_byte(cwc_pkg::ASCII_SPACE, 1'b0);
    send_byte(8'hC1, 1'b1);
  endtask

  // every start position is tried, so overlapping words all count
  task automatic test_overlap();
    idle_on = 1'b1;
    set_pattern(pack_chars("a a"), 64'd3);
    send_text(" a a a A.");
    idle_on = 1'b0;
  endtask

  // full length across both registers, zero length, overlong length
  task automatic test_pattern_length();
    set_pattern(pack_chars("Ab0@zZ[`{~ q-|M."), 64'd16);
    send_text("aB0@ZZ[`{~ Q-|m.");
    send_text("  AB0@zz[`{~ q-|M.!");
    send_text(" ab0`zz[`{~ q-|m.");
    send_text(" ab0@zz[`{~ q-|m.a");
    send_text("ab0@zz[`{~ q-|m");
    set_pattern(pack_chars(" "), 64'd0);
    send_text("    ");
    set_pattern(pack_chars("Ab0@zZ[`{~ q-|M."), {$urandom, $urandom} & ~64'h1F | 64'd17);
    send_text("ab0@zz[`{~ q-|m.");
    set_pattern(pack_chars("Ab0@zZ[`{~ q-|M."), {$urandom, $urandom} | 64'h1F);
    send_text(" ab0@zz[`{~ q-|m.?");
  endtask

  // end of text checks both the word before the last byte and the one at it
  task automatic test_text_end();
    set_pattern(pack_chars("x"), 64'd1);
    send_text("x");
    send_text(" X");
    send_text(" x!");
    send_text(" xa");
    send_text("xx");
    send_text("x");
  endtask

  // a long run of spaces against a single space pattern: one word per byte
  task automatic test_space_run();
    set_pattern(pack_chars(" "), 64'd1);
    for (int i = 0; i < 100; i++) send_byte(cwc_pkg::ASCII_SPACE, 1'b0);
    send_byte(cwc_pkg::ASCII_SPACE, 1'b1);
    send_text("  ");
  endtask

  // random patterns and texts built mostly from pattern words and spaces
  task automatic test_random();
    logic [2*cwc_pkg::CFG_DATA_W-1:0] chars;
    int unsigned len;
    int unsigned eff_len;
    int unsigned budget;
    int unsigned target;
    int unsigned pick;
    bit          paused;
    paused = 1'b0;
    for (int phase = 0; phase < 10; phase++) begin
      idle_on = 1'b0;
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        len = 0;
      end else if (pick == 1) begin
        len = $urandom_range(cwc_pkg::MAX_PATTERN + 1, 31);
      end else if (pick < 5) begin
        len = $urandom_range(5, cwc_pkg::MAX_PATTERN);
      end else begin
        len = $urandom_range(1, 4);
      end
      chars = {$urandom, $urandom, $urandom, $urandom};
      for (int k = 0; k < cwc_pkg::MAX_PATTERN; k++) begin
        if ($urandom_range(0, 5) != 0) begin
          chars[8*k +: 8] = random_case(
              cwc_pkg::byte_t'(cwc_pkg::ASCII_LOWER_A + $urandom_range(0, 25)));
        end
      end
      set_pattern(chars, 64'(len));
      eff_len = (len == 0) ? 1 :
                ((len > cwc_pkg::MAX_PATTERN) ? cwc_pkg::MAX_PATTERN : len);
      // no idling in the last phases
      idle_on = (phase < 8) ? ($urandom_range(0, 3) != 0) : 1'b0;
      budget = 0;
      while (budget < 105) begin
        text_q.delete();
        target = $urandom_range(1, 30);
        while (text_q.size() < target) begin
          pick = $urandom_range(0, 9);
          case (pick)
            0, 1, 2, 3: begin
              for (int k = 0; k < eff_len; k++) text_q.push_back(random_case(chars[8*k +: 8]));
            end
            4, 5: text_q.push_back(cwc_pkg::ASCII_SPACE);
            6: text_q.push_back(random_case(
                   cwc_pkg::byte_t'(cwc_pkg::ASCII_LOWER_A + $urandom_range(0, 25))));
            7: text_q.push_back(cwc_pkg::byte_t'($urandom_range(0, 255)));
            8: text_q.push_back(cwc_pkg::byte_t'($urandom_range(33, 64)));
            default: begin
              for (int k = 0; k < $urandom_range(1, eff_len); k++) begin
                text_q.push_back(random_case(chars[8*k +: 8]));
              end
            end
          endcase
        end
        send_queue(phase == 4 && !paused);
        if (phase == 4) begin
          paused = 1'b1;
        end
        budget += text_q.size();
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------
  initial begin
    clear_history();
    text_if.valid       <= 1'b0;
    text_if.text_byte   <= '0;
    text_if.end_of_text <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= cwc_pkg::CFG_PAT_LOW;
    cfg_data_i          <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_pattern();
    test_case_folding();
    test_overlap();
    test_pattern_length();
    test_text_end();
    test_space_run();
    test_random();

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[case_insensitive_word_counter] OK");
    end else begin
      $display("[case_insensitive_word_counter] ERROR");
    end
    $finish;
  end

  // hang guard
  initial begin
    #2_000_000;
    $display("[case_insensitive_word_counter] ERROR");
    $finish;
  end

endmodule

// ----- case_insensitive_word_counter.f -----
sv/cwc_pkg.sv
sv/cwc_text_if.sv
sv/cwc_result_if.sv
sv/case_insensitive_word_counter.sv
sv/cwc_checker.sv
bench/testbench.sv
